### design/bsec_pkg.sv
package bsec_pkg;

    localparam int LINE_LENGTH_W = 13;
    localparam logic [LINE_LENGTH_W-1:0] LINE_LENGTH_RESET = 13'd320;

    localparam int GROUP_RUNS = 6;
    localparam int FIRST_GROUP_RUN = 7;

    localparam int EDGE_W = 3;
    localparam int SCALE = 22;
    localparam int K_MIN = 2;
    localparam int K_MAX = 7;

    typedef logic [LINE_LENGTH_W-1:0] line_length_t;
    typedef logic [EDGE_W-1:0] edge_t;

endpackage

### design/bsec_runlen.sv
module bsec_runlen #(
    parameter int MAX_LINE = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsec_pkg::line_length_t         line_length_cur,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           pixel,
    output logic                           grp_valid,
    input  logic                           grp_ready,
    output logic [$clog2(MAX_LINE)-1:0]    grp_len [bsec_pkg::GROUP_RUNS],
    output logic [$clog2(MAX_LINE/3+1)-1:0] grp_start
);

    localparam int IDX_W = $clog2(MAX_LINE);
    localparam int RUN_W = $clog2(MAX_LINE/3 + 1);
    localparam int LL_W  = bsec_pkg::LINE_LENGTH_W;
    localparam int CW_A  = (RUN_W + 2 > LL_W) ? RUN_W + 2 : LL_W;
    localparam int CW    = (CW_A > IDX_W + 1) ? CW_A : IDX_W + 1;
    localparam int NR    = bsec_pkg::GROUP_RUNS;

    logic             prev_pixel_reg, prev_pixel_next;
    logic [IDX_W-1:0] pixel_index_reg, pixel_index_next;
    logic [IDX_W-1:0] run_start_reg, run_start_next;
    logic [RUN_W-1:0] run_count_reg, run_count_next;
    logic [2:0]       slot_reg, slot_next;
    logic [IDX_W-1:0] window_reg [NR];
    logic             grp_valid_reg, grp_valid_next;
    logic [IDX_W-1:0] grp_len_reg [NR];
    logic [RUN_W-1:0] grp_start_reg;

    logic [CW-1:0]    eff_len;
    logic [CW-1:0]    room_need;
    logic [CW-1:0]    index_plus;
    logic [RUN_W-1:0] run_inc;
    logic             accept;
    logic             prev_eff;
    logic             record;
    logic             emit;
    logic             line_end;
    logic [IDX_W-1:0] len_run;

    always_comb
    begin
        if (line_length_cur == '0)
        begin
            eff_len = CW'(1);
        end
        else if (CW'(line_length_cur) > CW'(MAX_LINE))
        begin
            eff_len = CW'(MAX_LINE);
        end
        else
        begin
            eff_len = CW'(line_length_cur);
        end
    end

    assign in_stall = grp_valid_reg && !grp_ready;
    assign accept   = in_valid && !in_stall;

    // a run can be recorded while 3 * (count + 1) <= length, i.e. count < length / 3
    assign run_inc    = run_count_reg + RUN_W'(1);
    assign room_need  = CW'(run_inc) + (CW'(run_inc) << 1);
    assign prev_eff   = (pixel_index_reg == '0) ? pixel : prev_pixel_reg;
    assign record     = (pixel != prev_eff) && (room_need <= eff_len);
    assign emit       = record && (slot_reg == 3'd1)
                        && (run_count_reg >= RUN_W'(bsec_pkg::FIRST_GROUP_RUN));
    assign len_run    = pixel_index_reg - run_start_reg;
    assign index_plus = CW'(pixel_index_reg) + CW'(1);
    assign line_end   = index_plus >= eff_len;

    always_comb
    begin
        prev_pixel_next  = prev_pixel_reg;
        pixel_index_next = pixel_index_reg;
        run_start_next   = run_start_reg;
        run_count_next   = run_count_reg;
        slot_next        = slot_reg;
        if (accept)
        begin
            prev_pixel_next = pixel;
            if (record)
            begin
                run_count_next = run_inc;
                run_start_next = pixel_index_reg;
                slot_next      = (slot_reg == 3'(NR - 1)) ? 3'd0 : slot_reg + 3'd1;
            end
            if (line_end)
            begin
                prev_pixel_next  = 1'b0;
                pixel_index_next = '0;
                run_start_next   = '0;
                run_count_next   = '0;
                slot_next        = 3'd0;
            end
            else
            begin
                pixel_index_next = pixel_index_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        if (grp_ready)
        begin
            grp_valid_next = 1'b0;
        end
        if (accept && emit)
        begin
            grp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pixel_reg  <= 1'b0;
            pixel_index_reg <= '0;
            run_start_reg   <= '0;
            run_count_reg   <= '0;
            slot_reg        <= 3'd0;
            grp_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_pixel_reg  <= prev_pixel_next;
            pixel_index_reg <= pixel_index_next;
            run_start_reg   <= run_start_next;
            run_count_reg   <= run_count_next;
            slot_reg        <= slot_next;
            grp_valid_reg   <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && record)
        begin
            window_reg[slot_reg] <= len_run;
        end
    end

    // slot 1 holds the oldest run of the group once the count is at 1 mod 6
    generate
        for (genvar k = 0; k < NR; k++)
        begin : g_grp
            localparam int SRC = (1 + k) % NR;
            always_ff @(posedge clk)
            begin
                if (accept && emit)
                begin
                    grp_len_reg[k] <= window_reg[SRC];
                end
            end
            assign grp_len[k] = grp_len_reg[k];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            grp_start_reg <= run_count_reg - RUN_W'(NR);
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp_start = grp_start_reg;

endmodule

### design/bsec_classify.sv
module bsec_classify #(
    parameter int MAX_LINE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            grp_valid,
    output logic                            grp_ready,
    input  logic [$clog2(MAX_LINE)-1:0]     grp_len [bsec_pkg::GROUP_RUNS],
    input  logic [$clog2(MAX_LINE/3+1)-1:0] grp_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [$clog2(MAX_LINE/3+1)-1:0] group_start,
    output bsec_pkg::edge_t                 edge_one,
    output bsec_pkg::edge_t                 edge_two,
    output bsec_pkg::edge_t                 edge_three,
    output bsec_pkg::edge_t                 edge_four
);

    localparam int IDX_W = $clog2(MAX_LINE);
    localparam int RUN_W = $clog2(MAX_LINE/3 + 1);
    localparam int P_W   = IDX_W + 3;
    localparam int E_W   = IDX_W + 1;
    localparam int T_W   = IDX_W + 7;
    localparam int NE    = 4;
    localparam int KM    = bsec_pkg::K_MAX;

    // stage one: group width and edge sums
    logic             v1_reg, v1_next;
    logic [P_W-1:0]   p1_reg;
    logic [E_W-1:0]   e1_reg [NE];
    logic [RUN_W-1:0] start1_reg;
    // stage two: scaled edges and odd multiples of the width
    logic             v2_reg, v2_next;
    logic [T_W-1:0]   s2_reg [NE];
    logic [T_W-1:0]   t2_reg [1:KM];
    logic [RUN_W-1:0] start2_reg;
    // stage three: result
    logic             v3_reg, v3_next;
    bsec_pkg::edge_t  k3_reg [NE];
    bsec_pkg::edge_t  k3_next [NE];
    logic [RUN_W-1:0] start3_reg;

    logic           r1, r2, r3;
    logic [P_W-1:0] p_sum;

    assign r3        = !v3_reg || !out_stall;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign grp_ready = r1;

    assign v1_next = r1 ? grp_valid : v1_reg;
    assign v2_next = r2 ? v1_reg : v2_reg;
    assign v3_next = r3 ? v2_reg : v3_reg;

    always_comb
    begin
        p_sum = '0;
        for (int i = 0; i < bsec_pkg::GROUP_RUNS; i++)
        begin
            p_sum = p_sum + P_W'(grp_len[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && grp_valid)
        begin
            p1_reg     <= p_sum;
            start1_reg <= grp_start;
            for (int i = 0; i < NE; i++)
            begin
                e1_reg[i] <= E_W'(grp_len[i]) + E_W'(grp_len[i+1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            start2_reg <= start1_reg;
            for (int i = 0; i < NE; i++)
            begin
                s2_reg[i] <= T_W'(e1_reg[i]) * T_W'(bsec_pkg::SCALE);
            end
            for (int j = 1; j <= KM; j++)
            begin
                t2_reg[j] <= T_W'(p1_reg) * T_W'(2 * j + 1);
            end
        end
    end

    // k modules when (2k-1)p <= 22e < (2k+1)p
    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            k3_next[i] = '0;
            for (int k = bsec_pkg::K_MIN; k <= KM; k++)
            begin
                if ((s2_reg[i] >= t2_reg[k-1]) && (s2_reg[i] < t2_reg[k]))
                begin
                    k3_next[i] = bsec_pkg::EDGE_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            start3_reg <= start2_reg;
            for (int i = 0; i < NE; i++)
            begin
                k3_reg[i] <= k3_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign out_valid   = v3_reg;
    assign group_start = start3_reg;
    assign edge_one    = k3_reg[0];
    assign edge_two    = k3_reg[1];
    assign edge_three  = k3_reg[2];
    assign edge_four   = k3_reg[3];

endmodule

### design/barcode_scanline_edge_classifier_core.sv
// Scanline edge classifier: takes one binarized pixel per clock unless stalled, run-length
// codes the line and, for every group of six runs after the first run, reports four
// adjacent-pair edge widths in modules (2..7, 0 when unclassifiable). The pixel side
// takes one item every cycle unless stalled; run tracking finishes in the cycle the pixel
// is taken, and a group then passes a four-register pipeline (group, sums, scaled compares,
// result), entered when the pixel closing the run after the group is taken. Input stall rises
// only while the group register is full and the result pipeline cannot move.
// line_length is written through its own valid/ready port, which is always ready.
module barcode_scanline_edge_classifier_core #(
    parameter int MAX_LINE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            line_length_valid,
    output logic                            line_length_ready,
    input  bsec_pkg::line_length_t          line_length,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [$clog2(MAX_LINE/3+1)-1:0] group_start,
    output bsec_pkg::edge_t                 edge_one,
    output bsec_pkg::edge_t                 edge_two,
    output bsec_pkg::edge_t                 edge_three,
    output bsec_pkg::edge_t                 edge_four
);

    localparam int IDX_W = $clog2(MAX_LINE);
    localparam int RUN_W = $clog2(MAX_LINE/3 + 1);

    bsec_pkg::line_length_t line_length_reg;
    logic                   grp_valid;
    logic                   grp_ready;
    logic [IDX_W-1:0]       grp_len [bsec_pkg::GROUP_RUNS];
    logic [RUN_W-1:0]       grp_start;

    assign line_length_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= bsec_pkg::LINE_LENGTH_RESET;
        end
        else if (line_length_valid && line_length_ready)
        begin
            line_length_reg <= line_length;
        end
    end

    bsec_runlen #(
        .MAX_LINE (MAX_LINE)
    ) u_runlen (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_length_cur (line_length_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .grp_valid       (grp_valid),
        .grp_ready       (grp_ready),
        .grp_len         (grp_len),
        .grp_start       (grp_start)
    );

    bsec_classify #(
        .MAX_LINE (MAX_LINE)
    ) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready),
        .grp_len     (grp_len),
        .grp_start   (grp_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .group_start (group_start),
        .edge_one    (edge_one),
        .edge_two    (edge_two),
        .edge_three  (edge_three),
        .edge_four   (edge_four)
    );

endmodule
